// ===== design/bis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler.
// -----------------------------------------------------------------------------
package bis_pkg;

    localparam int MaxWidth     = 256;
    localparam int MaxHeight    = 256;
    localparam int FractionBits = 16;
    localparam int ColBits      = $clog2(MaxWidth);
    localparam int RowBits      = $clog2(MaxHeight);
    localparam int AddrBits     = ColBits + RowBits;
    localparam int StepBits     = 24;
    localparam int DimBits      = 9;
    localparam int WeightBits   = FractionBits + 1;
    localparam int QueueDepth   = 2;

    localparam logic [2:0] RegSourceWidth  = 3'd0;
    localparam logic [2:0] RegSourceHeight = 3'd1;
    localparam logic [2:0] RegDestWidth    = 3'd2;
    localparam logic [2:0] RegDestHeight   = 3'd3;
    localparam logic [2:0] RegColumnStep   = 3'd4;
    localparam logic [2:0] RegRowStep      = 3'd5;

    localparam logic OpWrite   = 1'b0;
    localparam logic OpRequest = 1'b1;

    // One classified word passed from the front part to the back part.
    typedef struct packed {
        logic                    is_write;
        logic [RowBits-1:0]      r0;
        logic [RowBits-1:0]      r1;
        logic [ColBits-1:0]      c0;
        logic [ColBits-1:0]      c1;
        logic [FractionBits-1:0] fr;
        logic [FractionBits-1:0] fc;
        logic [23:0]             pixel;
    } bis_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3
    } bis_state_t;

endpackage : bis_pkg
`default_nettype wire

// ===== design/bilinear_image_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bilinear_image_scaler
// Resizes an RGB image held in a 256 x 256 frame store by bilinear weighting.
// -----------------------------------------------------------------------------
// Usage: an input word with opcode 0 stores one source pixel; a word with
// opcode 1 asks for one destination pixel and yields one output word.
// Writes outside the store are dropped. Configuration writes (index, data)
// are taken at any time and must only be issued while the block is idle.
// A write uses the frame store port once; a request reads it four times,
// once per neighbour from the single-ported store, and the next request is
// taken with the last of those reads. The front pipeline and a two-word queue
// keep accepting while the back part works.
// Reset clears all control state and loads the default registers; the store
// content is undefined until written. When the receiver stalls the result
// stays in the output register and the sequencer holds on its last read.
// -----------------------------------------------------------------------------
module bilinear_image_scaler
    import bis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [7:0]  pixel_row,
    input  wire logic [7:0]  pixel_column,
    input  wire logic [7:0]  in_blue,
    input  wire logic [7:0]  in_green,
    input  wire logic [7:0]  in_red,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_green,
    output logic [7:0]       out_red,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [DimBits-1:0]  source_width_reg;
    logic [DimBits-1:0]  source_height_reg;
    logic [DimBits-1:0]  dest_width_reg;
    logic [DimBits-1:0]  dest_height_reg;
    logic [StepBits-1:0] column_step_reg;
    logic [StepBits-1:0] row_step_reg;
    logic                f_valid;
    logic                f_ready;
    bis_cmd_t            f_cmd;
    logic                q_valid;
    logic                q_ready;
    bis_cmd_t            q_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= DimBits'(256);
            source_height_reg <= DimBits'(256);
            dest_width_reg    <= DimBits'(256);
            dest_height_reg   <= DimBits'(256);
            column_step_reg   <= StepBits'(65536);
            row_step_reg      <= StepBits'(65536);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                RegSourceWidth:  source_width_reg  <= cfg_data[DimBits-1:0];
                RegSourceHeight: source_height_reg <= cfg_data[DimBits-1:0];
                RegDestWidth:    dest_width_reg    <= cfg_data[DimBits-1:0];
                RegDestHeight:   dest_height_reg   <= cfg_data[DimBits-1:0];
                RegColumnStep:   column_step_reg   <= cfg_data;
                RegRowStep:      row_step_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    bis_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .pixel_row     (pixel_row),
        .pixel_column  (pixel_column),
        .in_blue       (in_blue),
        .in_green      (in_green),
        .in_red        (in_red),
        .source_width  (source_width_reg),
        .source_height (source_height_reg),
        .dest_width    (dest_width_reg),
        .dest_height   (dest_height_reg),
        .column_step   (column_step_reg),
        .row_step      (row_step_reg),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    bis_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    bis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red)
    );

endmodule : bilinear_image_scaler
`default_nettype wire

// ===== design/bis_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bis_front
// Accepts words, maps request coordinates onto source neighbours in a two
// stage pipeline and hands classified commands on.
// -----------------------------------------------------------------------------
module bis_front
    import bis_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [7:0]           pixel_row,
    input  wire logic [7:0]           pixel_column,
    input  wire logic [7:0]           in_blue,
    input  wire logic [7:0]           in_green,
    input  wire logic [7:0]           in_red,
    input  wire logic [DimBits-1:0]   source_width,
    input  wire logic [DimBits-1:0]   source_height,
    input  wire logic [DimBits-1:0]   dest_width,
    input  wire logic [DimBits-1:0]   dest_height,
    input  wire logic [StepBits-1:0]  column_step,
    input  wire logic [StepBits-1:0]  row_step,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output bis_cmd_t                  cmd
);

    localparam int PosBits = 8 + StepBits;

    logic            s1_valid_reg;
    logic            s1_write_reg;
    logic            s1_ignore_reg;
    logic [7:0]      s1_row_reg;
    logic [7:0]      s1_col_reg;
    logic [23:0]     s1_pixel_reg;
    logic [PosBits-1:0] s1_rpos_reg;
    logic [PosBits-1:0] s1_cpos_reg;
    logic            s1_advance;
    logic            s2_advance;
    logic            s2_valid_reg;
    bis_cmd_t        s2_cmd_reg;
    bis_cmd_t        cmd_next;
    logic            s2_drop;

    // Effective dimensions: zero acts as one, oversized acts as the maximum.
    function automatic logic [DimBits-1:0] eff_dim(input logic [DimBits-1:0] v,
                                                   input logic [DimBits-1:0] lim);
        logic [DimBits-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = DimBits'(1);
            else if (v > lim)
                r = lim;
            eff_dim = r;
        end
    endfunction

    localparam logic [DimBits-1:0] MaxW = DimBits'(MaxWidth);
    localparam logic [DimBits-1:0] MaxH = DimBits'(MaxHeight);

    // Map one axis from a registered product.
    function automatic logic [2*ColBits+FractionBits-1:0] map_axis(
        input logic [7:0]         d,
        input logic [DimBits-1:0] dcount,
        input logic [DimBits-1:0] scount,
        input logic [PosBits-1:0] pos);
        logic [DimBits-1:0]      last;
        logic [PosBits-1:0]      idx;
        logic [ColBits-1:0]      lo;
        logic [ColBits-1:0]      hi;
        logic [FractionBits-1:0] fr;
        begin
            last = scount - DimBits'(1);
            idx  = pos >> FractionBits;
            fr   = pos[FractionBits-1:0];
            if ({1'b0, d} == dcount - DimBits'(1)) begin
                lo = last[ColBits-1:0];
                hi = last[ColBits-1:0];
                fr = '0;
            end else if (idx >= PosBits'(last)) begin
                lo = last[ColBits-1:0];
                hi = last[ColBits-1:0];
            end else begin
                lo = idx[ColBits-1:0];
                hi = idx[ColBits-1:0] + ColBits'(1);
            end
            map_axis = {lo, hi, fr};
        end
    endfunction

    assign s2_advance = !s2_valid_reg || cmd_ready;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign in_ready   = s1_advance;

    // Stage one: the position products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            s1_write_reg  <= (opcode == OpWrite);
            s1_ignore_reg <= (32'(pixel_row) >= MaxHeight) || (32'(pixel_column) >= MaxWidth);
            s1_row_reg    <= pixel_row;
            s1_col_reg    <= pixel_column;
            s1_pixel_reg  <= {in_red, in_green, in_blue};
            s1_rpos_reg   <= PosBits'(pixel_row) * PosBits'(row_step);
            s1_cpos_reg   <= PosBits'(pixel_column) * PosBits'(column_step);
        end
    end

    // Stage two: neighbour indexes and fractions.
    always_comb
    begin
        logic [2*ColBits+FractionBits-1:0] rm;
        logic [2*ColBits+FractionBits-1:0] cm;
        rm = map_axis(s1_row_reg, eff_dim(dest_height, MaxH),
                      eff_dim(source_height, MaxH), s1_rpos_reg);
        cm = map_axis(s1_col_reg, eff_dim(dest_width, MaxW),
                      eff_dim(source_width, MaxW), s1_cpos_reg);
        cmd_next.is_write = s1_write_reg;
        cmd_next.pixel    = s1_pixel_reg;
        cmd_next.fr       = rm[FractionBits-1:0];
        cmd_next.fc       = cm[FractionBits-1:0];
        if (s1_write_reg)
        begin
            cmd_next.r0 = s1_row_reg[RowBits-1:0];
            cmd_next.r1 = s1_row_reg[RowBits-1:0];
            cmd_next.c0 = s1_col_reg[ColBits-1:0];
            cmd_next.c1 = s1_col_reg[ColBits-1:0];
        end
        else
        begin
            cmd_next.r0 = rm[2*ColBits+FractionBits-1 -: RowBits];
            cmd_next.r1 = rm[ColBits+FractionBits-1 -: RowBits];
            cmd_next.c0 = cm[2*ColBits+FractionBits-1 -: ColBits];
            cmd_next.c1 = cm[ColBits+FractionBits-1 -: ColBits];
        end
    end

    assign s2_drop = s1_write_reg && s1_ignore_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_advance)
        begin
            s2_valid_reg <= s1_valid_reg && !s2_drop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            s2_cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd       = s2_cmd_reg;

endmodule : bis_front
`default_nettype wire

// ===== design/bis_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bis_queue
// Short command queue between the front and back parts.
// -----------------------------------------------------------------------------
module bis_queue
    import bis_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire bis_cmd_t wr_cmd,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output bis_cmd_t      rd_cmd
);

    localparam int PtrBits = $clog2(QueueDepth);

    bis_cmd_t             slots_reg [QueueDepth];
    logic [PtrBits-1:0]   wptr_reg;
    logic [PtrBits-1:0]   rptr_reg;
    logic [PtrBits:0]     count_reg;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != (PtrBits+1)'(QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_cmd   = slots_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + PtrBits'(1);
            if (pop)
                rptr_reg <= rptr_reg + PtrBits'(1);
            if (push && !pop)
                count_reg <= count_reg + (PtrBits+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PtrBits+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wptr_reg] <= wr_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PtrBits+1)'(QueueDepth))
        else $error("queue count out of range");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (PtrBits+1)'(1)))
        else $error("queue count did not rise on push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - (PtrBits+1)'(1)))
        else $error("queue count did not fall on pop");

endmodule : bis_queue
`default_nettype wire

// ===== design/bis_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bis_back
// Frame store, four-read sequencer and the weighted sum of the neighbours.
// -----------------------------------------------------------------------------
module bis_back
    import bis_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire bis_cmd_t cmd,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [7:0]    out_blue,
    output logic [7:0]    out_green,
    output logic [7:0]    out_red
);

    localparam int WProdBits = 2 * WeightBits;
    localparam int AccBits   = WProdBits + 10;
    localparam logic [WeightBits-1:0] Unit = WeightBits'(1) << FractionBits;

    logic [23:0]          store [MaxWidth*MaxHeight];
    bis_state_t           state_reg;
    bis_state_t           state_next;
    bis_cmd_t             job_reg;
    logic [AddrBits-1:0]  rd_addr;
    logic                 rd_en;
    logic [23:0]          rd_data_reg;
    logic                 mac_valid_reg;
    logic [1:0]           mac_k_reg;
    logic [1:0]           rd_k;
    logic [WProdBits-1:0] wt_reg [4];
    logic [WProdBits-1:0] mac_w_reg;
    logic [AccBits-1:0]   acc_reg [3];
    logic                 res_done_reg;
    logic                 res_valid_reg;
    logic [23:0]          res_reg;
    logic                 take;
    logic                 slot_free;
    logic                 last_rd;

    // The result register frees as soon as the receiver takes it.
    assign slot_free = !res_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && !cmd.is_write) state_next = ST_RD0;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:
            begin
                if (take && !cmd.is_write)
                    state_next = ST_RD0;
                else if (take || !slot_free)
                    state_next = slot_free ? ST_IDLE : ST_RD3;
                else
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: read address and command acceptance.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_k    = 2'd0;
        rd_addr = {job_reg.r0, job_reg.c0};
        last_rd = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_RD0:
            begin
                cmd_ready = 1'b0;
                rd_en     = 1'b1;
                rd_k      = 2'd0;
                rd_addr   = {job_reg.r0, job_reg.c0};
            end
            ST_RD1:
            begin
                cmd_ready = 1'b0;
                rd_en     = 1'b1;
                rd_k      = 2'd1;
                rd_addr   = {job_reg.r0, job_reg.c1};
            end
            ST_RD2:
            begin
                cmd_ready = 1'b0;
                rd_en     = 1'b1;
                rd_k      = 2'd2;
                rd_addr   = {job_reg.r1, job_reg.c0};
            end
            ST_RD3:
            begin
                // The store port is busy with the last read, so only a request
                // may be taken here; a write waits for the idle state.
                cmd_ready = slot_free && !cmd.is_write;
                rd_en     = slot_free;
                last_rd   = slot_free;
                rd_k      = 2'd3;
                rd_addr   = {job_reg.r1, job_reg.c1};
            end
            default: cmd_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Latch a request and its four weights.
    always_ff @(posedge clk)
    begin
        if (take && !cmd.is_write)
        begin
            job_reg   <= cmd;
            wt_reg[0] <= (Unit - {1'b0, cmd.fr}) * (Unit - {1'b0, cmd.fc});
            wt_reg[1] <= (Unit - {1'b0, cmd.fr}) * {1'b0, cmd.fc};
            wt_reg[2] <= {1'b0, cmd.fr} * (Unit - {1'b0, cmd.fc});
            wt_reg[3] <= {1'b0, cmd.fr} * {1'b0, cmd.fc};
        end
    end

    // Single-ported frame store: writes from write commands, reads in sequence.
    always_ff @(posedge clk)
    begin
        if (take && cmd.is_write)
            store[{cmd.r0, cmd.c0}] <= cmd.pixel;
        else if (rd_en)
            rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_valid_reg <= 1'b0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            mac_valid_reg <= rd_en;
            res_done_reg  <= mac_valid_reg && (mac_k_reg == 2'd3);
        end
    end

    // The weight travels with its read, since a new request may reload the
    // weight registers while the last neighbour is still being summed.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mac_k_reg <= rd_k;
            mac_w_reg <= wt_reg[rd_k];
        end
    end

    // Multiply-accumulate, one neighbour a cycle per channel while the sequencer is not held on a full result slot.
    always_ff @(posedge clk)
    begin
        if (mac_valid_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (mac_k_reg == 2'd0)
                    acc_reg[ch] <= AccBits'(rd_data_reg[8*ch +: 8]) * AccBits'(mac_w_reg);
                else
                    acc_reg[ch] <= acc_reg[ch]
                                   + AccBits'(rd_data_reg[8*ch +: 8]) * AccBits'(mac_w_reg);
            end
        end
    end

    // Result register; filled in the cycle after the last accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_done_reg)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_done_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
                res_reg[8*ch +: 8] <= 8'(acc_reg[ch] >> (2 * FractionBits));
        end
    end

    // The accumulator stage leaves the slot free because RD3 held on a full slot.
    assign out_valid = res_valid_reg;
    assign out_blue  = res_reg[7:0];
    assign out_green = res_reg[15:8];
    assign out_red   = res_reg[23:16];

    a_done_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        last_rd |=> (mac_valid_reg && mac_k_reg == 2'd3))
        else $error("last neighbour read lost");
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (res_done_reg && res_valid_reg) |-> out_ready)
        else $error("result overwritten before it was taken");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_valid_reg && mac_k_reg != 2'd0) |-> (mac_k_reg == $past(mac_k_reg) + 2'd1))
        else $error("accumulation out of sequence");

endmodule : bis_back
`default_nettype wire
